### rtl/ofpw_pkg.sv
package ofpw_pkg;

  localparam int DEF_FRAME_BYTES   = 512;
  localparam int DEF_REPORT_BYTES  = 32;
  localparam int DEF_PAYLOAD_BYTES = 24;

  // byte position counter saturates at its top value
  localparam int          POS_W   = 6;
  localparam logic [5:0]  POS_MAX = 6'd63;

  // report header
  localparam logic [7:0] HDR_0 = 8'h55;
  localparam logic [7:0] HDR_1 = 8'h4F;
  localparam logic [7:0] HDR_2 = 8'h01;

  localparam logic [7:0] CMD_WRITE = 8'd1;
  localparam logic [7:0] CMD_CLEAR = 8'd2;
  localparam logic [7:0] CMD_STOCK = 8'd3;

  localparam logic [1:0] MODE_REPORT = 2'd0;
  localparam logic [1:0] MODE_FETCH  = 2'd1;
  localparam logic [1:0] MODE_ACK    = 2'd2;

  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_WRITTEN = 3'd1;
  localparam logic [2:0] ST_CLEARED = 3'd2;
  localparam logic [2:0] ST_STOCK   = 3'd3;
  localparam logic [2:0] ST_REJECT  = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] report_byte;
    logic       last_byte;
    logic [8:0] fetch_address;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] pixel_byte;
    logic       host_enabled;
    logic       frame_dirty;
  } out_t;

  // parsed report fields handed to the sequencer
  typedef struct packed {
    logic [7:0]  command_code;
    logic [15:0] write_offset;
    logic [7:0]  write_count;
    logic        fin_ok;
  } rpt_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COPY
  } state_t;

endpackage

### rtl/ofpw_frame.sv
module ofpw_frame import ofpw_pkg::*; #(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES,
  localparam int AW = $clog2(FRAME_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/ofpw_parse.sv
module ofpw_parse import ofpw_pkg::*; #(
  parameter int REPORT_BYTES  = DEF_REPORT_BYTES,
  parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
  localparam int PIW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     rbyte,
  input  logic           last,
  input  logic [PIW-1:0] stage_idx,
  output logic [7:0]     stage_data,
  output rpt_t           rpt
);

  logic [POS_W-1:0] pos;
  logic             hdr_good;
  logic [7:0]       command_code;
  logic [15:0]      write_offset;
  logic [7:0]       write_count;
  logic             fin_ok;
  logic [7:0]       stage [PAYLOAD_BYTES];

  logic             in_window;
  logic             length_ok;
  logic             stage_hit;
  logic [POS_W-1:0] stage_off;

  assign in_window = (7'(pos) < 7'(REPORT_BYTES)) && hdr_good;
  assign length_ok = (7'(pos) == 7'(REPORT_BYTES - 1));
  assign stage_off = pos - POS_W'(8);
  assign stage_hit = in_window && (7'(pos) >= 7'd8) && (7'(pos) < 7'(PAYLOAD_BYTES + 8));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      hdr_good     <= 1'b1;
      command_code <= '0;
      write_offset <= '0;
      write_count  <= '0;
      fin_ok       <= 1'b0;
    end else if (take) begin
      if (in_window) begin
        if (pos == 6'd0 && rbyte != HDR_0) begin
          hdr_good <= 1'b0;
        end else if (pos == 6'd1 && rbyte != HDR_1) begin
          hdr_good <= 1'b0;
        end else if (pos == 6'd2 && rbyte != HDR_2) begin
          hdr_good <= 1'b0;
        end else if (pos == 6'd3) begin
          command_code <= rbyte;
        end else if (pos == 6'd4) begin
          write_offset[7:0] <= rbyte;
        end else if (pos == 6'd5) begin
          write_offset[15:8] <= rbyte;
        end else if (pos == 6'd6) begin
          write_count <= rbyte;
        end
      end
      if (last) begin
        // header bytes come long before the final byte of a good-length report
        fin_ok   <= hdr_good && length_ok;
        pos      <= '0;
        hdr_good <= 1'b1;
      end else begin
        if (7'(pos) >= 7'(REPORT_BYTES - 1)) begin
          hdr_good <= 1'b0;
        end
        if (pos != POS_MAX) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage_hit) begin
      stage[stage_off[PIW-1:0]] <= rbyte;
    end
  end

  assign stage_data = stage[stage_idx];
  assign rpt = '{command_code: command_code, write_offset: write_offset,
                 write_count: write_count, fin_ok: fin_ok};

endmodule

### rtl/oled_frame_packet_writer.sv
// a byte, fetch or acknowledge moves IDLE to EXEC; EXEC registers its result strobe
// a frame write then walks the copied bytes in COPY, a clear the frame in CLEAR
// a new item is taken only in IDLE; busy covers EXEC and each walk of the frame port
// reset: a clearing pass zeroes the frame store, busy meanwhile
// the result strobe lasts one cycle and the receiver cannot stall it
module oled_frame_packet_writer import ofpw_pkg::*; #(
  parameter int FRAME_BYTES   = DEF_FRAME_BYTES,
  parameter int REPORT_BYTES  = DEF_REPORT_BYTES,
  parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  cmd,
  output logic result_valid,
  output out_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int AW  = $clog2(FRAME_BYTES);
  localparam int PIW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int CW  = (AW > PIW) ? AW : PIW;
  localparam int NW  = $clog2(FRAME_BYTES + 1);
  localparam int CAP = (PAYLOAD_BYTES < REPORT_BYTES - 8) ? PAYLOAD_BYTES : REPORT_BYTES - 8;

  state_t        state, state_next;
  in_t           item, item_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [NW-1:0] n_lim, n_lim_next;
  logic          clr_report, clr_report_next;
  logic          enabled, enabled_next;
  logic          dirty, dirty_next;
  logic          render_enable;
  out_t          result_next;
  logic          result_valid_next;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_base;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic [12:0]   fa_wide;
  logic [12:0]   fa_item;
  logic [7:0]    stage_data;
  rpt_t          rpt;
  logic [16:0]   room;
  logic [16:0]   n_calc;
  logic          fetch_ok;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign fa_wide   = 13'(cmd.fetch_address);
  assign fa_item   = 13'(item.fetch_address);
  assign mem_raddr = fa_wide[AW-1:0];
  assign fetch_ok  = (fa_item < 13'(FRAME_BYTES));

  // shared address adder: base is the write offset for a copy, zero for a clear
  assign mem_base  = (state == S_COPY) ? rpt.write_offset[AW-1:0] : '0;
  assign mem_waddr = mem_base + cnt[AW-1:0];

  ofpw_parse #(
    .REPORT_BYTES (REPORT_BYTES),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && cmd.mode == MODE_REPORT),
    .rbyte     (cmd.report_byte),
    .last      (cmd.last_byte),
    .stage_idx (cnt[PIW-1:0]),
    .stage_data(stage_data),
    .rpt       (rpt)
  );

  ofpw_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // copy length, clipped to the payload, the report and the room left in the frame
  always_comb begin
    room   = 17'(FRAME_BYTES) - 17'(rpt.write_offset);
    n_calc = 17'(rpt.write_count);
    if (n_calc > 17'(CAP)) begin
      n_calc = 17'(CAP);
    end
    if (n_calc > room) begin
      n_calc = room;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      render_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      render_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      cnt          <= '0;
      clr_report   <= 1'b0;
      enabled      <= 1'b0;
      dirty        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      clr_report   <= clr_report_next;
      enabled      <= enabled_next;
      dirty        <= dirty_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item   <= item_next;
    n_lim  <= n_lim_next;
    result <= result_next;
  end

  always_comb begin
    state_next        = state;
    item_next         = item;
    cnt_next          = cnt;
    n_lim_next        = n_lim;
    clr_report_next   = clr_report;
    enabled_next      = enabled;
    dirty_next        = dirty;
    result_next       = result;
    result_valid_next = 1'b0;
    mem_we            = 1'b0;
    mem_wdata         = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          item_next  = cmd;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next             = S_IDLE;
        result_valid_next      = 1'b1;
        result_next.status     = ST_PENDING;
        result_next.pixel_byte = '0;
        case (item.mode)
          MODE_REPORT: begin
            if (item.last_byte) begin
              if (!render_enable) begin
                result_next.status = ST_IGNORED;
              end else if (!rpt.fin_ok) begin
                result_next.status = ST_REJECT;
              end else if (rpt.command_code == CMD_CLEAR) begin
                result_valid_next = 1'b0;
                clr_report_next   = 1'b1;
                cnt_next          = '0;
                state_next        = S_CLEAR;
              end else if (rpt.command_code == CMD_STOCK) begin
                enabled_next       = 1'b0;
                dirty_next         = 1'b1;
                result_next.status = ST_STOCK;
              end else if (rpt.command_code != CMD_WRITE) begin
                result_next.status = ST_IGNORED;
              end else if (17'(rpt.write_offset) >= 17'(FRAME_BYTES)) begin
                result_next.status = ST_IGNORED;
              end else if (n_calc == '0) begin
                enabled_next       = 1'b1;
                dirty_next         = 1'b1;
                result_next.status = ST_WRITTEN;
              end else begin
                result_valid_next = 1'b0;
                n_lim_next        = n_calc[NW-1:0];
                cnt_next          = '0;
                state_next        = S_COPY;
              end
            end
          end
          MODE_FETCH: begin
            result_next.pixel_byte = fetch_ok ? mem_rdata : 8'd0;
          end
          MODE_ACK: begin
            if (render_enable && enabled) begin
              dirty_next = 1'b0;
            end
          end
          default: begin
            result_next.status = ST_IGNORED;
          end
        endcase
        result_next.host_enabled = enabled_next;
        result_next.frame_dirty  = dirty_next;
      end

      S_COPY: begin
        mem_we    = 1'b1;
        mem_wdata = stage_data;
        if (17'(cnt) + 17'd1 == 17'(n_lim)) begin
          enabled_next      = 1'b1;
          dirty_next        = 1'b1;
          result_valid_next = 1'b1;
          result_next       = '{status: ST_WRITTEN, pixel_byte: 8'd0,
                                host_enabled: 1'b1, frame_dirty: 1'b1};
          state_next        = S_IDLE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      S_CLEAR: begin
        mem_we = 1'b1;
        if (17'(cnt) == 17'(FRAME_BYTES - 1)) begin
          state_next = S_IDLE;
          // the pass after reset reports nothing
          if (clr_report) begin
            enabled_next      = 1'b1;
            dirty_next        = 1'b1;
            result_valid_next = 1'b1;
            result_next       = '{status: ST_CLEARED, pixel_byte: 8'd0,
                                  host_enabled: 1'b1, frame_dirty: 1'b1};
          end
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/ofpw_check.sv
module ofpw_check import ofpw_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid,
  input out_t result
);

  // a result strobe is never followed by another in the next cycle
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe on two cycles in a row");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("no busy after an accepted transfer");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status <= ST_IGNORED))
    else $error("status code out of range");

  a_pixel_pending: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pixel_byte != 8'd0) |-> (result.status == ST_PENDING))
    else $error("pixel data on a report result");

endmodule

bind oled_frame_packet_writer ofpw_check u_check (.*);

### sim/frame_writer_checker.sv
module frame_writer_checker import ofpw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  in_t  cmd,
  input  logic result_valid,
  input  out_t result,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_data,
  output int   errors,
  output int   outstanding
);

  localparam int FRAME_BYTES   = DEF_FRAME_BYTES;
  localparam int REPORT_BYTES  = DEF_REPORT_BYTES;
  localparam int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES;

  logic [7:0]       frame_mem [FRAME_BYTES];
  logic [7:0]       stage_mem [PAYLOAD_BYTES];
  logic [POS_W-1:0] pos_q;
  logic             hdr_ok;
  logic [7:0]       code_q;
  logic [15:0]      offs_q;
  logic [7:0]       count_q;
  logic             host_on;
  logic             dirty_q;
  logic             render_en;

  out_t due_q[$];
  out_t head;
  int   fail_cnt = 0;
  int   depth = 0;

  assign errors      = fail_cnt;
  assign outstanding = depth;

  // works out the result of one accepted item and moves the shadow state on
  function automatic out_t next_result(in_t x);
    out_t             r;
    logic [POS_W-1:0] pos;
    int               n;
    int               i;
    r = '0;
    r.status = ST_PENDING;
    case (x.mode)
      MODE_REPORT: begin
        pos = pos_q;
        if (pos < REPORT_BYTES && hdr_ok) begin
          case (pos)
            6'd0: if (x.report_byte != HDR_0) hdr_ok = 1'b0;
            6'd1: if (x.report_byte != HDR_1) hdr_ok = 1'b0;
            6'd2: if (x.report_byte != HDR_2) hdr_ok = 1'b0;
            6'd3: code_q = x.report_byte;
            6'd4: offs_q[7:0] = x.report_byte;
            6'd5: offs_q[15:8] = x.report_byte;
            6'd6: count_q = x.report_byte;
            default: begin
              if (pos >= 8 && pos - 8 < PAYLOAD_BYTES) stage_mem[pos - 8] = x.report_byte;
            end
          endcase
        end
        if (x.last_byte) begin
          if (!render_en) begin
            r.status = ST_IGNORED;
          end else if (pos != REPORT_BYTES - 1 || !hdr_ok) begin
            r.status = ST_REJECT;
          end else if (code_q == CMD_CLEAR) begin
            foreach (frame_mem[k]) frame_mem[k] = '0;
            host_on  = 1'b1;
            dirty_q  = 1'b1;
            r.status = ST_CLEARED;
          end else if (code_q == CMD_STOCK) begin
            host_on  = 1'b0;
            dirty_q  = 1'b1;
            r.status = ST_STOCK;
          end else if (code_q != CMD_WRITE || offs_q >= FRAME_BYTES) begin
            r.status = ST_IGNORED;
          end else begin
            // copy length is clipped to the staged payload, the report and the room left
            n = count_q;
            if (n > PAYLOAD_BYTES) n = PAYLOAD_BYTES;
            if (n > REPORT_BYTES - 8) n = REPORT_BYTES - 8;
            if (n > FRAME_BYTES - int'(offs_q)) n = FRAME_BYTES - int'(offs_q);
            for (i = 0; i < n; i++) frame_mem[int'(offs_q) + i] = stage_mem[i];
            host_on  = 1'b1;
            dirty_q  = 1'b1;
            r.status = ST_WRITTEN;
          end
          pos_q  = '0;
          hdr_ok = 1'b1;
        end else begin
          if (pos >= REPORT_BYTES - 1) hdr_ok = 1'b0;
          if (pos != POS_MAX) pos_q = pos + 1'b1;
        end
      end
      MODE_FETCH: begin
        if (x.fetch_address < FRAME_BYTES) r.pixel_byte = frame_mem[x.fetch_address];
      end
      MODE_ACK: begin
        if (render_en && host_on) dirty_q = 1'b0;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.host_enabled = host_on;
    r.frame_dirty  = dirty_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (frame_mem[k]) frame_mem[k] = '0;
      foreach (stage_mem[k]) stage_mem[k] = '0;
      pos_q     = '0;
      hdr_ok    = 1'b1;
      code_q    = '0;
      offs_q    = '0;
      count_q   = '0;
      host_on   = 1'b0;
      dirty_q   = 1'b0;
      render_en = 1'b1;
      due_q.delete();
      depth = 0;
    end else begin
      if (result_valid) begin
        if (due_q.size() == 0) begin
          fail_cnt++;
          $error("result strobe with no transfer waiting for it");
        end else begin
          head = due_q.pop_front();
          check_field("status", head.status, result.status);
          check_field("pixel_byte", head.pixel_byte, result.pixel_byte);
          check_field("host_enabled", head.host_enabled, result.host_enabled);
          check_field("frame_dirty", head.frame_dirty, result.frame_dirty);
        end
      end
      if (cfg_valid && cfg_ready) render_en = cfg_data;
      if (start && !busy) due_q.push_back(next_result(cmd));
      depth = due_q.size();
    end
  end

endmodule

### sim/tb_oled_frame_packet_writer.sv
module tb_oled_frame_packet_writer;
  import ofpw_pkg::*;

  localparam int         ITEMS     = 1300;
  localparam logic [1:0] MODE_NONE = 2'd3;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_t  cmd;
  logic result_valid;
  out_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;
  int   errors;
  int   outstanding;

  int items_sent = 0;
  int burst_left = 1;

  oled_frame_packet_writer i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  frame_writer_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // start stays high across a burst, gaps drop it for a random while
  task automatic send_item(input in_t x);
    @(negedge clk);
    start <= 1'b1;
    cmd   <= x;
    do @(posedge clk); while (busy);
    if (x.mode != MODE_NONE) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic misc_item(input logic [1:0] mode, input logic [8:0] addr);
    in_t it;
    it.mode          = mode;
    it.report_byte   = 8'($urandom);
    it.last_byte     = 1'($urandom);
    it.fetch_address = addr;
    send_item(it);
  endtask

  task automatic send_report(input logic [7:0] code, input logic [15:0] offs,
                             input logic [7:0] cnt, input int len, input bit corrupt);
    in_t it;
    int  bad_pos;
    int  i;
    bad_pos = $urandom_range(0, 2);
    for (i = 0; i < len; i++) begin
      // fetches and acks may land in the middle of a report
      if ($urandom_range(0, 9) == 0)
        misc_item($urandom_range(0, 1) ? MODE_FETCH : MODE_ACK, 9'($urandom_range(0, 511)));
      it.mode          = MODE_REPORT;
      it.report_byte   = 8'($urandom);
      it.last_byte     = (i == len - 1);
      it.fetch_address = 9'($urandom);
      case (i)
        0: it.report_byte = HDR_0;
        1: it.report_byte = HDR_1;
        2: it.report_byte = HDR_2;
        3: it.report_byte = code;
        4: it.report_byte = offs[7:0];
        5: it.report_byte = offs[15:8];
        6: it.report_byte = cnt;
        default: ;
      endcase
      if (corrupt && i == bad_pos) it.report_byte ^= 8'($urandom_range(1, 255));
      send_item(it);
    end
  endtask

  // waits for the block to drain before touching the register
  task automatic set_render(input logic v);
    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          base;
    int          pick;
    int          ph;
    logic [7:0]  code;
    logic [7:0]  cnt;
    logic [15:0] offs;
    in_t         noise;

    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_render(1'b1);

    // directed part
    misc_item(MODE_FETCH, 9'd0);
    misc_item(MODE_FETCH, 9'd511);
    misc_item(MODE_ACK, 9'd0);
    misc_item(MODE_NONE, 9'd0);
    send_report(CMD_CLEAR, 16'd0, 8'd0, 32, 1'b0);
    send_report(CMD_WRITE, 16'd0, 8'd24, 32, 1'b0);
    misc_item(MODE_FETCH, 9'd23);
    send_report(CMD_WRITE, 16'd500, 8'd255, 32, 1'b0);
    misc_item(MODE_FETCH, 9'd511);
    send_report(CMD_WRITE, 16'd512, 8'd4, 32, 1'b0);
    send_report(CMD_WRITE, 16'hFFFF, 8'd4, 32, 1'b0);
    send_report(CMD_WRITE, 16'd40, 8'd0, 32, 1'b0);
    misc_item(MODE_ACK, 9'd0);
    send_report(CMD_STOCK, 16'd0, 8'd0, 32, 1'b0);
    misc_item(MODE_ACK, 9'd0);
    send_report(8'hFF, 16'd0, 8'd0, 32, 1'b0);
    send_report(8'h00, 16'd0, 8'd0, 32, 1'b0);
    send_report(CMD_WRITE, 16'd8, 8'd8, 32, 1'b1);
    send_report(CMD_WRITE, 16'd8, 8'd8, 31, 1'b0);
    send_report(CMD_WRITE, 16'd8, 8'd8, 33, 1'b0);
    send_report(CMD_WRITE, 16'd8, 8'd8, 1, 1'b0);
    send_report(CMD_WRITE, 16'd8, 8'd8, 70, 1'b0);
    set_render(1'b0);
    send_report(CMD_CLEAR, 16'd0, 8'd0, 32, 1'b0);
    misc_item(MODE_ACK, 9'd0);

    // random phases, reports off in two of them
    base = items_sent;
    for (ph = 0; ph < 6; ph++) begin
      set_render((ph == 2 || ph == 4) ? 1'b0 : 1'b1);
      while (items_sent < base + (ph + 1) * (ITEMS - base) / 6) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3:  offs = 16'($urandom_range(0, 511));
            4, 5, 6:     offs = 16'($urandom_range(480, 511));
            7:           offs = 16'($urandom_range(0, 15));
            default:     offs = 16'($urandom_range(512, 65535));
          endcase
          cnt = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 30))
                                            : 8'($urandom_range(0, 255));
          pick = $urandom_range(0, 99);
          if (pick < 70)      code = CMD_WRITE;
          else if (pick < 75) code = CMD_CLEAR;
          else if (pick < 88) code = CMD_STOCK;
          else                code = 8'($urandom);
          if ($urandom_range(0, 5) == 0)
            send_report(code, offs, cnt, $urandom_range(1, 40), 1'($urandom_range(0, 1)));
          else
            send_report(code, offs, cnt, 32, 1'b0);
        end else if (pick < 85) begin
          misc_item(MODE_FETCH, 9'($urandom_range(0, 511)));
        end else if (pick < 93) begin
          misc_item(MODE_ACK, 9'($urandom_range(0, 511)));
        end else begin
          noise = 20'($urandom);
          send_item(noise);
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/ofpw_pkg.sv
rtl/ofpw_frame.sv
rtl/ofpw_parse.sv
rtl/oled_frame_packet_writer.sv
rtl/ofpw_check.sv
sim/frame_writer_checker.sv
sim/tb_oled_frame_packet_writer.sv
